### sv/mbts_pkg.sv
// ----------------------------------------------------------------------------
// mbts_pkg
// Shared constants, class codes, pattern tables and types for the
// magic-byte payload type sniffer.
// ----------------------------------------------------------------------------
package mbts_pkg;

  localparam int HeadDepth  = 12;
  localparam int CountMax   = 15;
  localparam int DoctypeLen = 14;
  localparam int TagLen     = 5;

  localparam logic [7:0] LtChar = 8'h3C;  // '<'

  localparam logic [3:0] TYPE_NONE = 4'd0;
  localparam logic [3:0] TYPE_JSON = 4'd1;
  localparam logic [3:0] TYPE_HTML = 4'd2;
  localparam logic [3:0] TYPE_XML  = 4'd3;
  localparam logic [3:0] TYPE_PNG  = 4'd4;
  localparam logic [3:0] TYPE_JPEG = 4'd5;
  localparam logic [3:0] TYPE_GIF  = 4'd6;
  localparam logic [3:0] TYPE_WEBP = 4'd7;
  localparam logic [3:0] TYPE_PDF  = 4'd8;
  localparam logic [3:0] TYPE_ZIP  = 4'd9;
  localparam logic [3:0] TYPE_MP4  = 4'd10;
  localparam logic [3:0] TYPE_MPEG = 4'd11;

  // Payload state as seen after the current byte is folded in
  typedef struct packed {
    logic [HeadDepth-1:0][7:0] head;
    logic [3:0]                count;
    logic                      html_seen;
  } view_t;

  // "<!DOCTYPE html"
  function automatic logic [7:0] doctype_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h3C;
      4'd1:    c = 8'h21;
      4'd2:    c = 8'h44;
      4'd3:    c = 8'h4F;
      4'd4:    c = 8'h43;
      4'd5:    c = 8'h54;
      4'd6:    c = 8'h59;
      4'd7:    c = 8'h50;
      4'd8:    c = 8'h45;
      4'd9:    c = 8'h20;
      4'd10:   c = 8'h68;
      4'd11:   c = 8'h74;
      4'd12:   c = 8'h6D;
      4'd13:   c = 8'h6C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "<html"
  function automatic logic [7:0] tag_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h3C;
      3'd1:    c = 8'h68;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h6D;
      3'd4:    c = 8'h6C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### sv/mbts_if.sv
// ----------------------------------------------------------------------------
// mbts_in_if / mbts_out_if
// Valid/ready channels for payload bytes and class results.
// ----------------------------------------------------------------------------
interface mbts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       is_last;

  modport source (output valid, output byte_value, output is_last, input ready);
  modport sink   (input valid, input byte_value, input is_last, output ready);
endinterface

interface mbts_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] type_code;

  modport source (output valid, output type_code, input ready);
  modport sink   (input valid, input type_code, output ready);
endinterface

### sv/magic_byte_type_sniffer_top.sv
// ----------------------------------------------------------------------------
// magic_byte_type_sniffer_top
// Payload type sniffer: one byte per transaction in, one class code per
// payload out.
//
// in_ch carries payload bytes in order; is_last marks the final byte.
// out_ch carries one type_code per payload, issued for the last byte.
// Each byte goes into an input register. From there it is folded into the
// payload state and classified, and the class code of a last byte lands in
// the result register, which drives out_ch.valid.
// One byte is accepted every cycle, unless a last byte waits in the input
// register while the result register is held; the state update of the byte
// held in the input register is the loop that sets this rate.
// Reset (synchronous, active low) empties both registers and clears the
// payload state. When the receiver stalls, the code waits in the result
// register; non-last bytes keep flowing, and a further last byte waits in
// the input register, which then holds in_ch.ready low.
// ----------------------------------------------------------------------------
module magic_byte_type_sniffer_top (
  input  logic        clk,
  input  logic        rst_n,
  mbts_in_if.sink     in_ch,
  mbts_out_if.source  out_ch
);

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_v_r;
  logic [3:0] out_code_r;
  logic       out_load;
  logic       s1_fire;
  logic [3:0] code_nxt;
  mbts_pkg::view_t view;

  assign out_load    = !out_v_r || out_ch.ready;
  assign s1_fire     = in_v_r && (!in_last_r || out_load);
  assign in_ch.ready = !in_v_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (out_load) begin
        out_v_r <= in_v_r && in_last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.byte_value;
      in_last_r <= in_ch.is_last;
    end
    if (out_load && in_v_r && in_last_r) begin
      out_code_r <= code_nxt;
    end
  end

  mbts_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (s1_fire),
    .byte_value (in_byte_r),
    .is_last    (in_last_r),
    .view       (view)
  );

  mbts_classify u_classify (
    .view      (view),
    .type_code (code_nxt)
  );

  assign out_ch.valid     = out_v_r;
  assign out_ch.type_code = out_code_r;

endmodule

### sv/mbts_track.sv
// ----------------------------------------------------------------------------
// mbts_track
// Per-payload state: head bytes, saturating length and the two pattern
// matchers. Presents the state with the current byte folded in.
// ----------------------------------------------------------------------------
module mbts_track (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [7:0]         byte_value,
  input  logic               is_last,
  output mbts_pkg::view_t    view
);

  logic [mbts_pkg::HeadDepth-1:0][7:0] head_r;
  logic [3:0] count_r, count_nxt;
  logic [3:0] dt_r, dt_nxt;
  logic [2:0] tg_r, tg_nxt;
  logic       seen_r;
  logic       dt_hit, tg_hit;

  always_comb begin
    view.head = head_r;
    if (count_r < 4'(mbts_pkg::HeadDepth)) begin
      view.head[count_r] = byte_value;
    end

    dt_hit = 1'b0;
    if (dt_r < 4'(mbts_pkg::DoctypeLen) &&
        mbts_pkg::doctype_char(dt_r) == byte_value) begin
      if (dt_r == 4'(mbts_pkg::DoctypeLen - 1)) begin
        dt_nxt = 4'd0;
        dt_hit = 1'b1;
      end else begin
        dt_nxt = dt_r + 4'd1;
      end
    end else begin
      dt_nxt = (byte_value == mbts_pkg::LtChar) ? 4'd1 : 4'd0;
    end

    tg_hit = 1'b0;
    if (tg_r < 3'(mbts_pkg::TagLen) &&
        mbts_pkg::tag_char(tg_r) == byte_value) begin
      if (tg_r == 3'(mbts_pkg::TagLen - 1)) begin
        tg_nxt = 3'd0;
        tg_hit = 1'b1;
      end else begin
        tg_nxt = tg_r + 3'd1;
      end
    end else begin
      tg_nxt = (byte_value == mbts_pkg::LtChar) ? 3'd1 : 3'd0;
    end

    count_nxt = (count_r == 4'(mbts_pkg::CountMax)) ? count_r : count_r + 4'd1;

    view.count     = count_nxt;
    view.html_seen = seen_r | dt_hit | tg_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 4'd0;
      dt_r    <= 4'd0;
      tg_r    <= 3'd0;
      seen_r  <= 1'b0;
    end else if (fire) begin
      if (is_last) begin
        count_r <= 4'd0;
        dt_r    <= 4'd0;
        tg_r    <= 3'd0;
        seen_r  <= 1'b0;
      end else begin
        count_r <= count_nxt;
        dt_r    <= dt_nxt;
        tg_r    <= tg_nxt;
        seen_r  <= view.html_seen;
      end
    end
  end

  // head bytes are only read once written within the current payload
  always_ff @(posedge clk) begin
    if (fire) begin
      head_r <= view.head;
    end
  end

endmodule

### sv/mbts_classify.sv
// ----------------------------------------------------------------------------
// mbts_classify
// Priority classification of a payload from its head bytes, length and
// html flag.
// ----------------------------------------------------------------------------
module mbts_classify (
  input  mbts_pkg::view_t view,
  output logic [3:0]      type_code
);

  logic [7:0] h0, h1, h2, h3, h4, h5, h6, h7, h8, h9, h10, h11;

  assign h0  = view.head[0];
  assign h1  = view.head[1];
  assign h2  = view.head[2];
  assign h3  = view.head[3];
  assign h4  = view.head[4];
  assign h5  = view.head[5];
  assign h6  = view.head[6];
  assign h7  = view.head[7];
  assign h8  = view.head[8];
  assign h9  = view.head[9];
  assign h10 = view.head[10];
  assign h11 = view.head[11];

  always_comb begin
    if (view.count < 4'd4) begin
      type_code = mbts_pkg::TYPE_NONE;
    end else if (h0 == 8'h7B || h0 == 8'h5B) begin
      type_code = mbts_pkg::TYPE_JSON;
    end else if (h0 == mbts_pkg::LtChar) begin
      type_code = view.html_seen ? mbts_pkg::TYPE_HTML : mbts_pkg::TYPE_XML;
    end else if (h0 == 8'h89 && h1 == 8'h50 && h2 == 8'h4E && h3 == 8'h47) begin
      type_code = mbts_pkg::TYPE_PNG;
    end else if (h0 == 8'hFF && h1 == 8'hD8) begin
      type_code = mbts_pkg::TYPE_JPEG;
    end else if (h0 == 8'h47 && h1 == 8'h49 && h2 == 8'h46 && h3 == 8'h38) begin
      type_code = mbts_pkg::TYPE_GIF;
    end else if (view.count >= 4'd12 &&
                 h0 == 8'h52 && h1 == 8'h49 && h2 == 8'h46 && h3 == 8'h46 &&
                 h8 == 8'h57 && h9 == 8'h45 && h10 == 8'h42 && h11 == 8'h50) begin
      type_code = mbts_pkg::TYPE_WEBP;
    end else if (h0 == 8'h25 && h1 == 8'h50 && h2 == 8'h44 && h3 == 8'h46) begin
      type_code = mbts_pkg::TYPE_PDF;
    end else if (h0 == 8'h50 && h1 == 8'h4B && h2 == 8'h03 && h3 == 8'h04) begin
      type_code = mbts_pkg::TYPE_ZIP;
    end else if (view.count >= 4'd8 &&
                 h4 == 8'h66 && h5 == 8'h74 && h6 == 8'h79 && h7 == 8'h70) begin
      type_code = mbts_pkg::TYPE_MP4;
    end else if (h0 == 8'h49 && h1 == 8'h44 && h2 == 8'h33) begin
      type_code = mbts_pkg::TYPE_MPEG;
    end else begin
      type_code = mbts_pkg::TYPE_NONE;
    end
  end

endmodule

### sv/mbts_checker.sv
// ----------------------------------------------------------------------------
// mbts_checker
// Port-level checks for the sniffer, bound to the top level.
// ----------------------------------------------------------------------------
module mbts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_is_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_type_code
);

  // a pending result is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // class codes stay in the defined range
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_type_code <= mbts_pkg::TYPE_MPEG)
    else $error("type_code out of range");

  // a fresh result comes from an accepted last byte, via the input and result registers
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_is_last, 2))
    else $error("result without a last byte");

  // a drained output never throttles the input
  a_no_throttle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

endmodule

bind magic_byte_type_sniffer_top mbts_checker u_mbts_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_is_last    (in_ch.is_last),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_type_code (out_ch.type_code)
);

### bench/tb_magic_byte_type_sniffer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_magic_byte_type_sniffer_top
// Self-checking bench for the payload type sniffer. A short directed table
// with fixed class codes is followed by randomized payloads: well-formed
// file headers with random bodies, embedded and broken markup patterns,
// short and long payloads, and noise. A bit-accurate predictor computes the
// class code of every payload, and each code out of the block is compared
// in order. Both channel sides idle at random, and the receiver holds off
// once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_magic_byte_type_sniffer_top;

  localparam int ClkHalf    = 6;
  localparam int RandBytes  = 1150;
  localparam int HoldCycles = 400;
  localparam int HoldAfter  = 20;
  localparam int DrainLimit = 20000;
  localparam int Settle     = 8;

  localparam logic [111:0] DOCTYPE_PAT = "<!DOCTYPE html";
  localparam logic [111:0] TAG_PAT     = "<html";

  typedef enum int {
    PK_JSON, PK_TAG, PK_DOCTYPE, PK_XML, PK_PNG, PK_JPEG, PK_GIF, PK_WEBP,
    PK_PDF, PK_ZIP, PK_MP4, PK_MPEG, PK_SHORT, PK_NOISE, PK_RESTART
  } payload_kind_t;

  logic clk;
  logic rst_n;

  mbts_in_if  in_ch ();
  mbts_out_if out_ch ();

  magic_byte_type_sniffer_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // payload state of the predictor
  logic [7:0] pl_head [mbts_pkg::HeadDepth];
  logic [3:0] pl_count;
  logic [3:0] dt_prog;
  logic [2:0] tg_prog;
  logic       pl_html;

  logic [3:0] type_codes_due [$];
  int         fail_count;

  // fixed code tagged onto the transaction in flight (directed rows)
  logic       pin_q;
  logic [3:0] pin_code_q;

  logic [7:0] dir_byte [$];
  logic       dir_last [$];
  logic [3:0] dir_code [$];
  logic [7:0] pl_bytes [$];

  int tx_run, rx_run;
  bit tx_calm, rx_calm;

  initial begin
    clk = 1'b0;
    forever #(ClkHalf) clk = ~clk;
  end

  function automatic void clear_payload();
    for (int i = 0; i < mbts_pkg::HeadDepth; i++) pl_head[i] = 8'h00;
    pl_count = '0;
    dt_prog  = '0;
    tg_prog  = '0;
    pl_html  = 1'b0;
  endfunction

  function automatic logic [3:0] match_step(input logic [3:0] prog, input logic [7:0] b,
                                            input logic [111:0] pat, input int len,
                                            output bit done);
    logic [7:0] want;
    done = 1'b0;
    want = (prog < len) ? pat[(len - 1 - prog) * 8 +: 8] : 8'h00;
    if (prog < len && want == b) begin
      if (prog + 1 == len) begin
        done = 1'b1;
        return 4'd0;
      end
      return prog + 4'd1;
    end
    return (b == mbts_pkg::LtChar) ? 4'd1 : 4'd0;
  endfunction

  function automatic logic [3:0] classify_payload();
    logic [31:0] w0, w4, w8;
    w0 = {pl_head[0], pl_head[1], pl_head[2], pl_head[3]};
    w4 = {pl_head[4], pl_head[5], pl_head[6], pl_head[7]};
    w8 = {pl_head[8], pl_head[9], pl_head[10], pl_head[11]};
    if (pl_count < 4) return mbts_pkg::TYPE_NONE;
    if (pl_head[0] == "{" || pl_head[0] == "[") return mbts_pkg::TYPE_JSON;
    if (pl_head[0] == mbts_pkg::LtChar)
      return pl_html ? mbts_pkg::TYPE_HTML : mbts_pkg::TYPE_XML;
    if (w0 == {8'h89, "PNG"}) return mbts_pkg::TYPE_PNG;
    if (pl_head[0] == 8'hFF && pl_head[1] == 8'hD8) return mbts_pkg::TYPE_JPEG;
    if (w0 == "GIF8") return mbts_pkg::TYPE_GIF;
    if (pl_count >= 12 && w0 == "RIFF" && w8 == "WEBP") return mbts_pkg::TYPE_WEBP;
    if (w0 == "%PDF") return mbts_pkg::TYPE_PDF;
    if (w0 == {"PK", 8'h03, 8'h04}) return mbts_pkg::TYPE_ZIP;
    if (pl_count >= 8 && w4 == "ftyp") return mbts_pkg::TYPE_MP4;
    if (w0[31:8] == "ID3") return mbts_pkg::TYPE_MPEG;
    return mbts_pkg::TYPE_NONE;
  endfunction

  // folds one byte into the payload state; returns 1 when a code is due
  function automatic bit fold_byte(input logic [7:0] b, input logic last,
                                   output logic [3:0] code);
    bit         hit;
    logic [3:0] tg;
    code = mbts_pkg::TYPE_NONE;
    if (pl_count < mbts_pkg::HeadDepth) pl_head[pl_count] = b;
    dt_prog = match_step(dt_prog, b, DOCTYPE_PAT, mbts_pkg::DoctypeLen, hit);
    if (hit) pl_html = 1'b1;
    tg = match_step({1'b0, tg_prog}, b, TAG_PAT, mbts_pkg::TagLen, hit);
    tg_prog = tg[2:0];
    if (hit) pl_html = 1'b1;
    if (pl_count < mbts_pkg::CountMax) pl_count = pl_count + 4'd1;
    if (!last) return 1'b0;
    code = classify_payload();
    clear_payload();
    return 1'b1;
  endfunction

  function automatic int draw_gap(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      calm     = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(8, 40);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [7:0] pad_byte();
    if ($urandom_range(0, 7) == 0)
      return DOCTYPE_PAT[$urandom_range(0, mbts_pkg::DoctypeLen - 1) * 8 +: 8];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_text(input logic [143:0] s, input int n);
    for (int i = 0; i < n; i++) pl_bytes.push_back(s[(n - 1 - i) * 8 +: 8]);
  endtask

  task automatic table_row(input logic [7:0] b, input logic last, input logic [3:0] code);
    dir_byte.push_back(b);
    dir_last.push_back(last);
    dir_code.push_back(code);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic pin,
                           input logic [3:0] code);
    int gap;
    gap = draw_gap(tx_run, tx_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.byte_value <= b;
    in_ch.is_last    <= last;
    pin_q            <= pin;
    pin_code_q       <= code;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // scoreboard and predictor update
  always @(posedge clk) begin
    logic [3:0] due, code;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (type_codes_due.size() == 0) begin
          $error("type_code: no transaction expected, actual %0d", out_ch.type_code);
          fail_count++;
        end else begin
          due = type_codes_due.pop_front();
          if (out_ch.type_code !== due) begin
            $error("type_code: expected %0d, actual %0d", due, out_ch.type_code);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (fold_byte(in_ch.byte_value, in_ch.is_last, code))
          type_codes_due.push_back(pin_q ? pin_code_q : code);
      end
    end
  end

  // receiver
  initial begin
    int gap;
    int rx_count;
    bit held;
    rx_count = 0;
    held     = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(rx_run, rx_calm);
      if (!held && rx_count == HoldAfter) begin
        held = 1'b1;
        gap  = HoldCycles;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      rx_count++;
    end
  end

  initial begin
    #(2_000_000);
    $display("FAIL magic_byte_type_sniffer_top");
    $finish;
  end

  // sender and run control
  initial begin
    int            sent, hdr, target, idx, waited;
    payload_kind_t kind;
    fail_count = 0;
    tx_run     = 0;
    rx_run     = 0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    clear_payload();
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.byte_value <= 8'h00;
    in_ch.is_last    <= 1'b0;
    pin_q            <= 1'b0;
    pin_code_q       <= mbts_pkg::TYPE_NONE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // single byte payload, also the lowest byte value
    table_row(8'h00, 1, mbts_pkg::TYPE_NONE);
    table_row("{", 0, mbts_pkg::TYPE_NONE);
    table_row("a", 0, mbts_pkg::TYPE_NONE);
    table_row("b", 0, mbts_pkg::TYPE_NONE);
    table_row("}", 1, mbts_pkg::TYPE_JSON);
    table_row(8'h89, 0, mbts_pkg::TYPE_NONE);
    table_row("P", 0, mbts_pkg::TYPE_NONE);
    table_row("N", 0, mbts_pkg::TYPE_NONE);
    table_row("G", 1, mbts_pkg::TYPE_PNG);
    table_row(8'hFF, 0, mbts_pkg::TYPE_NONE);
    table_row(8'hD8, 0, mbts_pkg::TYPE_NONE);
    table_row(8'hFF, 0, mbts_pkg::TYPE_NONE);
    table_row(8'hE0, 1, mbts_pkg::TYPE_JPEG);
    // second '<' restarts the tag matcher
    table_row("<", 0, mbts_pkg::TYPE_NONE);
    table_row("<", 0, mbts_pkg::TYPE_NONE);
    table_row("h", 0, mbts_pkg::TYPE_NONE);
    table_row("t", 0, mbts_pkg::TYPE_NONE);
    table_row("m", 0, mbts_pkg::TYPE_NONE);
    table_row("l", 1, mbts_pkg::TYPE_HTML);
    // three bytes is too short to classify
    table_row("I", 0, mbts_pkg::TYPE_NONE);
    table_row("D", 0, mbts_pkg::TYPE_NONE);
    table_row("3", 1, mbts_pkg::TYPE_NONE);
    table_row("I", 0, mbts_pkg::TYPE_NONE);
    table_row("D", 0, mbts_pkg::TYPE_NONE);
    table_row("3", 0, mbts_pkg::TYPE_NONE);
    table_row(8'h00, 1, mbts_pkg::TYPE_MPEG);

    for (int i = 0; i < dir_byte.size(); i++)
      send_byte(dir_byte[i], dir_last[i], dir_last[i], dir_code[i]);

    sent = 0;
    while (sent < RandBytes) begin
      pl_bytes.delete();
      kind = payload_kind_t'($urandom_range(0, PK_RESTART));
      case (kind)
        PK_JSON:    pl_bytes.push_back($urandom_range(0, 1) ? "{" : "[");
        PK_TAG: begin
          pl_bytes.push_back("<");
          repeat ($urandom_range(0, 6)) pl_bytes.push_back(pad_byte());
          push_text(TAG_PAT, mbts_pkg::TagLen);
        end
        PK_DOCTYPE: push_text(DOCTYPE_PAT, mbts_pkg::DoctypeLen);
        PK_XML:     push_text("<?xml", 5);
        PK_PNG:     push_text({8'h89, "PNG"}, 4);
        PK_JPEG:    push_text({8'hFF, 8'hD8}, 2);
        PK_GIF:     push_text("GIF8", 4);
        PK_WEBP: begin
          push_text("RIFF", 4);
          repeat (4) pl_bytes.push_back(pad_byte());
          push_text("WEBP", 4);
        end
        PK_PDF:     push_text("%PDF", 4);
        PK_ZIP:     push_text({"PK", 8'h03, 8'h04}, 4);
        PK_MP4: begin
          repeat (4) pl_bytes.push_back(pad_byte());
          push_text("ftyp", 4);
        end
        PK_MPEG:    push_text("ID3", 3);
        PK_SHORT:   repeat ($urandom_range(1, 3)) pl_bytes.push_back(pad_byte());
        PK_RESTART: begin
          case ($urandom_range(0, 2))
            0:       push_text("<<html", 6);
            1:       push_text("<!DOC<html", 10);
            default: push_text("<!DOCTYPE htm<html", 18);
          endcase
        end
        default: ;
      endcase

      if (kind != PK_SHORT) begin
        // broken header
        if (kind != PK_NOISE && $urandom_range(0, 5) == 0) begin
          idx = $urandom_range(0, pl_bytes.size() - 1);
          pl_bytes[idx] = pl_bytes[idx] ^ 8'($urandom_range(1, 255));
        end
        // markup pattern later in the body, sometimes one byte short
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(0, 14)) pl_bytes.push_back(pad_byte());
          if ($urandom_range(0, 1))
            push_text(DOCTYPE_PAT, mbts_pkg::DoctypeLen - $urandom_range(0, 1));
          else
            push_text(TAG_PAT, mbts_pkg::TagLen - $urandom_range(0, 1));
        end
        hdr = (pl_bytes.size() > 0) ? pl_bytes.size() : 1;
        case ($urandom_range(0, 9)) inside
          [0:5]:   target = $urandom_range(hdr, (hdr > 12) ? hdr : 12);
          [6:8]:   target = $urandom_range(hdr, (hdr > 20) ? hdr : 20);
          default: target = $urandom_range(hdr, (hdr > 48) ? hdr : 48);
        endcase
        while (pl_bytes.size() < target) pl_bytes.push_back(pad_byte());
      end

      for (int i = 0; i < pl_bytes.size(); i++)
        send_byte(pl_bytes[i], i == pl_bytes.size() - 1, 1'b0, mbts_pkg::TYPE_NONE);
      sent += pl_bytes.size();
    end
    in_ch.valid <= 1'b0;

    waited = 0;
    while (type_codes_due.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (Settle) @(posedge clk);
    if (type_codes_due.size() != 0) begin
      $error("type_code: %0d transactions never arrived", type_codes_due.size());
      fail_count++;
    end

    if (fail_count == 0)
      $display("PASS magic_byte_type_sniffer_top");
    else
      $display("FAIL magic_byte_type_sniffer_top");
    $finish;
  end

endmodule
